/* rtl/core/kwm_pkg.sv */
// Shared constants, item type and list-mask helper for the k-way sorted merge.
`default_nettype none

package kwm_pkg;

    localparam int MAX_LISTS   = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_W     = 32;
    localparam int LIST_W      = $clog2(MAX_LISTS);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = LIST_W + PTR_W;
    localparam int USER_W      = LIST_W + 1;
    localparam int CFG_W       = 3;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    typedef logic [MAX_LISTS-1:0] list_mask_t;

    // One classified input beat as it sits in the queue between front and back.
    typedef struct packed {
        logic [LIST_W-1:0]  list;
        logic               in_use;
        logic               has_value;
        logic               closes;
        logic [VALUE_W-1:0] value;
    } kwm_item_t;

    // A zero count acts as one list, and counts above the list total saturate.
    function automatic list_mask_t use_mask(input logic [CFG_W-1:0] cfg);
        int         n;
        list_mask_t m;
        n = int'(cfg);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_LISTS) begin
            n = MAX_LISTS;
        end
        for (int i = 0; i < MAX_LISTS; i++) begin
            m[i] = (i < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/k_way_sorted_merge.sv */
// Top level of the k-way sorted merge: configuration register and front/back engines.
//
// Each input beat may append one value to one list's 16-entry queue and may close that
// list; the block then emits merged values, smallest head first with ties going to the
// lower list index, for as long as every open list in use has a queued value. An input
// beat leaves the two-entry input queue and is applied while the merge engine is idle. An
// emitted value is followed by a refill step if the emitting list has another value
// queued (the queue memory's registered read refills that list's head register), and a
// merge pass that does not end the set stops after a check that finds nothing; the value
// that ends a set ends its pass at once. An output beat waits in the output register
// while m_tready is low, the merge engine holds meanwhile, and up to two input beats are
// buffered. The last value of a set carries m_tlast. The lists_in_use register is taken
// from cfg_data whenever cfg_valid is high and must only change while the block is idle.
// There is no clearing pass after reset.
`default_nettype none

module k_way_sorted_merge (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [kwm_pkg::CFG_W-1:0]           cfg_data,  // lists_in_use
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic signed [kwm_pkg::VALUE_W-1:0]  s_tdata,   // value
    input  wire logic [kwm_pkg::USER_W-1:0]          s_tuser,   // list_index, has_value
    input  wire logic                                s_tlast,   // closes_list
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic signed [kwm_pkg::VALUE_W-1:0]       m_tdata,   // merged_value
    output logic [kwm_pkg::USER_W-1:0]               m_tuser,   // source_list, dropped_flag
    output logic                                     m_tlast    // set_last
);

    logic [kwm_pkg::CFG_W-1:0]   lists_in_use_reg;
    kwm_pkg::list_mask_t         use_mask;
    logic                        item_valid;
    logic                        item_ready;
    kwm_pkg::kwm_item_t          item;

    assign cfg_ready = 1'b1;
    assign use_mask  = kwm_pkg::use_mask(lists_in_use_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lists_in_use_reg <= kwm_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            lists_in_use_reg <= cfg_data;
        end
    end

    kwm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .use_mask   (use_mask),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    kwm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .use_mask   (use_mask),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/core/kwm_front.sv */
// Input side: accepts beats, classifies them against the lists in use, queues them.
`default_nettype none

module kwm_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic signed [kwm_pkg::VALUE_W-1:0]  s_tdata,  // value
    input  wire logic [kwm_pkg::USER_W-1:0]          s_tuser,  // list_index, has_value
    input  wire logic                                s_tlast,  // closes_list
    input  wire kwm_pkg::list_mask_t                 use_mask,
    output logic                                     item_valid,
    input  wire logic                                item_ready,
    output kwm_pkg::kwm_item_t                       item
);

    kwm_pkg::kwm_item_t                  fifo_reg [kwm_pkg::FIFO_DEPTH];
    logic [kwm_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [kwm_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [kwm_pkg::FIFO_CNT_W-1:0]      count_reg;
    logic [kwm_pkg::FIFO_CNT_W-1:0]      count_next;
    kwm_pkg::kwm_item_t                  in_item;
    logic                                push;
    logic                                pop;

    always_comb begin
        in_item.list      = s_tuser[kwm_pkg::LIST_W-1:0];
        in_item.in_use    = use_mask[s_tuser[kwm_pkg::LIST_W-1:0]];
        in_item.has_value = s_tuser[kwm_pkg::LIST_W];
        in_item.closes    = s_tlast;
        in_item.value     = $unsigned(s_tdata);
    end

    assign s_tready   = (count_reg != kwm_pkg::FIFO_CNT_W'(kwm_pkg::FIFO_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = fifo_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + kwm_pkg::FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - kwm_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= kwm_pkg::FIFO_PTR_W'(wr_ptr_reg + kwm_pkg::FIFO_PTR_W'(1));
            end
            if (pop) begin
                rd_ptr_reg <= kwm_pkg::FIFO_PTR_W'(rd_ptr_reg + kwm_pkg::FIFO_PTR_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kwm_back.sv */
// Merge engine: per-list queues, head registers, smallest-head selection, output register.
`default_nettype none

module kwm_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire kwm_pkg::list_mask_t                 use_mask,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire kwm_pkg::kwm_item_t                  item,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic signed [kwm_pkg::VALUE_W-1:0]       m_tdata,  // merged_value
    output logic [kwm_pkg::USER_W-1:0]               m_tuser,  // source_list, dropped_flag
    output logic                                     m_tlast   // set_last
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_MERGE  = 3'b010,
        ST_REFILL = 3'b100
    } back_state_t;

    back_state_t                         state_reg;
    back_state_t                         state_next;

    logic [kwm_pkg::VALUE_W-1:0]         mem [kwm_pkg::MAX_LISTS * kwm_pkg::QUEUE_DEPTH];
    logic [kwm_pkg::VALUE_W-1:0]         rd_data_reg;
    logic [kwm_pkg::VALUE_W-1:0]         head_reg [kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::PTR_W-1:0]           rp_reg [kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::CNT_W-1:0]           cnt_reg [kwm_pkg::MAX_LISTS];
    kwm_pkg::list_mask_t                 closed_reg;
    logic                                overflow_reg;
    logic [kwm_pkg::LIST_W-1:0]          refill_list_reg;

    logic                                m_valid_reg;
    logic [kwm_pkg::VALUE_W-1:0]         out_value_reg;
    logic [kwm_pkg::LIST_W-1:0]          out_src_reg;
    logic                                out_last_reg;
    logic                                out_drop_reg;

    kwm_pkg::list_mask_t                 item_sel;
    kwm_pkg::list_mask_t                 has;
    kwm_pkg::list_mask_t                 win;
    logic                                merge_ready;
    logic                                all_closed;
    logic                                any_queued;
    logic                                done;
    logic [kwm_pkg::LIST_W-1:0]          best_idx;
    logic [kwm_pkg::VALUE_W-1:0]         best_val;
    logic [kwm_pkg::PTR_W-1:0]           best_rp;
    logic [kwm_pkg::CNT_W-1:0]           best_cnt;
    logic [kwm_pkg::PTR_W-1:0]           item_rp;
    logic [kwm_pkg::CNT_W-1:0]           item_cnt;
    logic                                item_closed;
    logic [kwm_pkg::PTR_W-1:0]           wr_ptr;
    logic                                take;
    logic                                app_ok;
    logic                                app_drop;
    logic                                slot_free;
    logic                                merge_check;
    logic                                emit;

    always_comb begin
        item_sel    = '0;
        has         = '0;
        merge_ready = 1'b1;
        all_closed  = 1'b1;
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
            item_sel[i] = (item.list == kwm_pkg::LIST_W'(i));
            has[i]      = use_mask[i] && (cnt_reg[i] != '0);
            if (use_mask[i] && (cnt_reg[i] == '0) && !closed_reg[i]) begin
                merge_ready = 1'b0;
            end
            if (use_mask[i] && !closed_reg[i]) begin
                all_closed = 1'b0;
            end
        end

        // Pairwise compares: a head wins if it is strictly below every lower-indexed
        // head and not above any higher-indexed head, which breaks ties low.
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
            win[i] = has[i];
            for (int j = 0; j < kwm_pkg::MAX_LISTS; j++) begin
                if ((j != i) && has[j]) begin
                    if (j < i) begin
                        win[i] = win[i] && ($signed(head_reg[i]) < $signed(head_reg[j]));
                    end else begin
                        win[i] = win[i] && ($signed(head_reg[i]) <= $signed(head_reg[j]));
                    end
                end
            end
        end

        best_idx    = '0;
        best_val    = '0;
        best_rp     = '0;
        best_cnt    = '0;
        item_rp     = '0;
        item_cnt    = '0;
        item_closed = 1'b0;
        done        = 1'b1;
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
            if (win[i]) begin
                best_idx = kwm_pkg::LIST_W'(i);
                best_val = head_reg[i];
                best_rp  = rp_reg[i];
                best_cnt = cnt_reg[i];
            end
            if (item_sel[i]) begin
                item_rp     = rp_reg[i];
                item_cnt    = cnt_reg[i];
                item_closed = closed_reg[i];
            end
            if (use_mask[i] && !(closed_reg[i] && ((cnt_reg[i] == '0) ||
                    (win[i] && (cnt_reg[i] == kwm_pkg::CNT_W'(1)))))) begin
                done = 1'b0;
            end
        end
    end

    assign any_queued  = |has;
    assign item_ready  = (state_reg == ST_IDLE);
    assign take        = item_valid && item_ready;
    assign app_ok      = item.in_use && item.has_value && !item_closed &&
                         (item_cnt != kwm_pkg::CNT_W'(kwm_pkg::QUEUE_DEPTH));
    assign app_drop    = item.in_use && item.has_value && !app_ok;
    assign wr_ptr      = item_rp + item_cnt[kwm_pkg::PTR_W-1:0];
    assign slot_free   = !m_valid_reg || m_tready;
    assign merge_check = (state_reg == ST_MERGE) && slot_free;
    assign emit        = merge_check && any_queued && merge_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (merge_check) begin
                    priority if (!emit || done) begin
                        state_next = ST_IDLE;
                    end else if (best_cnt > kwm_pkg::CNT_W'(1)) begin
                        state_next = ST_REFILL;
                    end else begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_REFILL: begin
                state_next = ST_MERGE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            closed_reg   <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
                rp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (take) begin
                if (app_drop) begin
                    overflow_reg <= 1'b1;
                end
                for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
                    if (item_sel[i]) begin
                        if (app_ok) begin
                            cnt_reg[i] <= cnt_reg[i] + kwm_pkg::CNT_W'(1);
                        end
                        if (item.in_use && item.closes) begin
                            closed_reg[i] <= 1'b1;
                        end
                    end
                end
            end
            // An empty set with every list closed reopens without a beat.
            if (merge_check && !any_queued && all_closed) begin
                closed_reg <= '0;
            end
            if (emit) begin
                m_valid_reg  <= 1'b1;
                overflow_reg <= 1'b0;
                for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
                    if (win[i]) begin
                        cnt_reg[i] <= cnt_reg[i] - kwm_pkg::CNT_W'(1);
                        rp_reg[i]  <= kwm_pkg::PTR_W'(rp_reg[i] + kwm_pkg::PTR_W'(1));
                    end
                end
                if (done) begin
                    closed_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && app_ok) begin
            mem[{item.list, wr_ptr}] <= item.value;
        end
        rd_data_reg <= mem[{best_idx, kwm_pkg::PTR_W'(best_rp + kwm_pkg::PTR_W'(1))}];
    end

    always_ff @(posedge aclk) begin
        if (take && app_ok && (item_cnt == '0)) begin
            head_reg[item.list] <= item.value;
        end
        if (state_reg == ST_REFILL) begin
            head_reg[refill_list_reg] <= rd_data_reg;
        end
        if (emit) begin
            refill_list_reg <= best_idx;
            out_value_reg   <= best_val;
            out_src_reg     <= best_idx;
            out_last_reg    <= done;
            out_drop_reg    <= overflow_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = $signed(out_value_reg);
    assign m_tuser  = {out_drop_reg, out_src_reg};
    assign m_tlast  = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && done) |=> (closed_reg == '0))
        else $error("lists not reopened after the last beat of a set");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REFILL) |-> (cnt_reg[refill_list_reg] != '0))
        else $error("head refill for a list with an empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> !overflow_reg)
        else $error("drop flag still pending after it was sent");

    for (genvar g = 0; g < kwm_pkg::MAX_LISTS; g++) begin : g_cnt_chk
        assert property (@(posedge aclk) disable iff (!aresetn)
            cnt_reg[g] <= kwm_pkg::CNT_W'(kwm_pkg::QUEUE_DEPTH))
            else $error("queue count above queue depth");
    end

endmodule

`default_nettype wire
